FILE: hw/rtl/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

  // Number format and port widths.
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned OPND_W    = 32;

  // Internal value width, wide enough for every unclamped result.
  localparam int unsigned VAL_W = 64;

  // Divider geometry: the numerator is |a| shifted by FRAC_BITS, padded
  // with leading zeros to a whole number of two-bit stages.
  localparam int unsigned DIV_BITS_PER_STAGE = 2;
  localparam int unsigned NUM_W      = OPND_W + FRAC_BITS;
  localparam int unsigned DIV_STAGES = (NUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int unsigned NUMP_W     = DIV_STAGES * DIV_BITS_PER_STAGE;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } fpa_op_t;

  // Side information that travels with each transaction.
  typedef struct packed {
    fpa_op_t                  op;
    logic signed [VAL_W-1:0]  val;
    logic                     cmp;
    logic                     dz;
    logic                     neg;
  } fpa_side_t;

endpackage

FILE: hw/rtl/fpa_front.sv
`timescale 1ns / 1ps
module fpa_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_vld,
  input  logic [3:0]                              in_opcode,
  input  logic signed [fpa_pkg::OPND_W-1:0]       in_operand_a,
  input  logic signed [fpa_pkg::OPND_W-1:0]       in_operand_b,
  output logic                                    fr_vld,
  output fpa_pkg::fpa_side_t                      fr_side,
  output logic [fpa_pkg::NUMP_W-1:0]              fr_num,
  output logic [fpa_pkg::OPND_W-1:0]              fr_den
);

  localparam int unsigned VW = fpa_pkg::VAL_W;
  localparam int unsigned OW = fpa_pkg::OPND_W;
  localparam int unsigned F  = fpa_pkg::FRAC_BITS;
  localparam logic signed [VW-1:0] HALF  = VW'(1) <<< (F - 1);
  localparam logic signed [VW-1:0] FMASK = (VW'(1) <<< F) - VW'(1);

  // Stage 1: input register.
  logic                 v1_r;
  fpa_pkg::fpa_op_t     op1_r;
  logic signed [OW-1:0] a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
    op1_r <= fpa_pkg::fpa_op_t'(in_opcode);
    a1_r  <= in_operand_a;
    b1_r  <= in_operand_b;
  end

  // Stage 2: product, simple operations, divider operands.
  logic signed [VW-1:0] a_x, b_x, simple_nxt;
  logic                 cmp_nxt, dz_nxt;
  logic [OW-1:0]        mag_a, mag_b;

  always_comb begin
    a_x        = VW'(a1_r);
    b_x        = VW'(b1_r);
    simple_nxt = '0;
    cmp_nxt    = 1'b0;
    dz_nxt     = 1'b0;
    mag_a      = a1_r[OW-1] ? (~a1_r + OW'(1)) : a1_r;
    mag_b      = b1_r[OW-1] ? (~b1_r + OW'(1)) : b1_r;
    case (op1_r)
      fpa_pkg::OP_ADD:     simple_nxt = a_x + b_x;
      fpa_pkg::OP_SUB:     simple_nxt = a_x - b_x;
      fpa_pkg::OP_DIV:     dz_nxt     = (b1_r == '0);
      fpa_pkg::OP_GT:      cmp_nxt    = (a1_r > b1_r);
      fpa_pkg::OP_LT:      cmp_nxt    = (a1_r < b1_r);
      fpa_pkg::OP_GE:      cmp_nxt    = (a1_r >= b1_r);
      fpa_pkg::OP_LE:      cmp_nxt    = (a1_r <= b1_r);
      fpa_pkg::OP_EQ:      cmp_nxt    = (a1_r == b1_r);
      fpa_pkg::OP_NE:      cmp_nxt    = (a1_r != b1_r);
      fpa_pkg::OP_MIN:     simple_nxt = (a1_r < b1_r) ? a_x : b_x;
      fpa_pkg::OP_MAX:     simple_nxt = (a1_r > b1_r) ? a_x : b_x;
      fpa_pkg::OP_INC:     simple_nxt = a_x + VW'(1);
      fpa_pkg::OP_DEC:     simple_nxt = a_x - VW'(1);
      fpa_pkg::OP_TOINT:   simple_nxt = (a1_r[OW-1] ? (a_x + FMASK) : a_x) >>> F;
      fpa_pkg::OP_FROMINT: simple_nxt = a_x <<< F;
      default:             simple_nxt = '0;
    endcase
  end

  logic                  v2_r;
  fpa_pkg::fpa_side_t    s2_r;
  logic signed [VW-1:0]  prod2_r;
  logic [fpa_pkg::NUMP_W-1:0] num2_r;
  logic [OW-1:0]         den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    prod2_r    <= a_x * b_x;
    s2_r.op    <= op1_r;
    s2_r.val   <= simple_nxt;
    s2_r.cmp   <= cmp_nxt;
    s2_r.dz    <= dz_nxt;
    s2_r.neg   <= a1_r[OW-1] ^ b1_r[OW-1];
    num2_r     <= fpa_pkg::NUMP_W'({mag_a, F'(0)});
    den2_r     <= mag_b;
  end

  // Stage 3: rounded magnitude of the product.
  logic [VW-1:0] mmag_nxt;

  always_comb begin
    if (prod2_r[VW-1]) begin
      mmag_nxt = (~prod2_r + HALF + VW'(1)) >> F;
    end else begin
      mmag_nxt = (prod2_r + HALF) >> F;
    end
  end

  logic                  v3_r;
  fpa_pkg::fpa_side_t    s3_r;
  logic [VW-1:0]         mmag3_r;
  logic                  mneg3_r;
  logic [fpa_pkg::NUMP_W-1:0] num3_r;
  logic [OW-1:0]         den3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    s3_r    <= s2_r;
    mmag3_r <= mmag_nxt;
    mneg3_r <= prod2_r[VW-1];
    num3_r  <= num2_r;
    den3_r  <= den2_r;
  end

  // Stage 4: apply the product sign.
  fpa_pkg::fpa_side_t s4_nxt;

  always_comb begin
    s4_nxt = s3_r;
    if (s3_r.op == fpa_pkg::OP_MUL) begin
      s4_nxt.val = mneg3_r ? -$signed(mmag3_r) : $signed(mmag3_r);
    end
  end

  logic                  v4_r;
  fpa_pkg::fpa_side_t    s4_r;
  logic [fpa_pkg::NUMP_W-1:0] num4_r;
  logic [OW-1:0]         den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    s4_r   <= s4_nxt;
    num4_r <= num3_r;
    den4_r <= den3_r;
  end

  assign fr_vld  = v4_r;
  assign fr_side = s4_r;
  assign fr_num  = num4_r;
  assign fr_den  = den4_r;

endmodule

FILE: hw/rtl/fpa_div.sv
`timescale 1ns / 1ps
module fpa_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              dv_in_vld,
  input  fpa_pkg::fpa_side_t                dv_in_side,
  input  logic [fpa_pkg::NUMP_W-1:0]        dv_in_num,
  input  logic [fpa_pkg::OPND_W-1:0]        dv_in_den,
  output logic                              dv_out_vld,
  output fpa_pkg::fpa_side_t                dv_out_side,
  output logic [fpa_pkg::NUMP_W-1:0]        dv_out_quo,
  output logic [fpa_pkg::OPND_W-1:0]        dv_out_rem,
  output logic [fpa_pkg::OPND_W-1:0]        dv_out_den
);

  localparam int unsigned NS = fpa_pkg::DIV_STAGES;
  localparam int unsigned NW = fpa_pkg::NUMP_W;
  localparam int unsigned OW = fpa_pkg::OPND_W;
  localparam int unsigned BPS = fpa_pkg::DIV_BITS_PER_STAGE;

  // Restoring division, numerator bits shift out at the top while
  // quotient bits shift in at the bottom of the same register.
  logic                vld_r  [NS+1];
  fpa_pkg::fpa_side_t  side_r [NS+1];
  logic [NW-1:0]       nq_r   [NS+1];
  logic [OW-1:0]       rem_r  [NS+1];
  logic [OW-1:0]       den_r  [NS+1];

  assign vld_r[0]  = dv_in_vld;
  assign side_r[0] = dv_in_side;
  assign nq_r[0]   = dv_in_num;
  assign rem_r[0]  = '0;
  assign den_r[0]  = dv_in_den;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NW-1:0] nq_nxt;
    logic [OW-1:0] rem_nxt;
    logic [OW:0]   trial;

    // Two quotient bits per stage.
    always_comb begin
      nq_nxt  = nq_r[s];
      rem_nxt = rem_r[s];
      trial   = '0;
      for (int k = 0; k < BPS; k++) begin
        trial = {rem_nxt, nq_nxt[NW-1]};
        if (trial >= {1'b0, den_r[s]}) begin
          rem_nxt = OW'(trial - {1'b0, den_r[s]});
          nq_nxt  = {nq_nxt[NW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[OW-1:0];
          nq_nxt  = {nq_nxt[NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      side_r[s+1] <= side_r[s];
      nq_r[s+1]   <= nq_nxt;
      rem_r[s+1]  <= rem_nxt;
      den_r[s+1]  <= den_r[s];
    end
  end

  assign dv_out_vld  = vld_r[NS];
  assign dv_out_side = side_r[NS];
  assign dv_out_quo  = nq_r[NS];
  assign dv_out_rem  = rem_r[NS];
  assign dv_out_den  = den_r[NS];

endmodule

FILE: hw/rtl/fpa_back.sv
`timescale 1ns / 1ps
module fpa_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              bk_vld,
  input  fpa_pkg::fpa_side_t                bk_side,
  input  logic [fpa_pkg::NUMP_W-1:0]        bk_quo,
  input  logic [fpa_pkg::OPND_W-1:0]        bk_rem,
  input  logic [fpa_pkg::OPND_W-1:0]        bk_den,
  output logic                              out_valid,
  output logic signed [fpa_pkg::OPND_W-1:0] out_result_value,
  output logic                              out_compare_true,
  output logic                              out_overflow,
  output logic                              out_divide_by_zero
);

  localparam int unsigned VW = fpa_pkg::VAL_W;
  localparam int unsigned NW = fpa_pkg::NUMP_W;
  localparam int unsigned OW = fpa_pkg::OPND_W;
  localparam logic signed [VW-1:0] HI = (VW'(1) <<< (fpa_pkg::WORD_BITS - 1)) - VW'(1);
  localparam logic signed [VW-1:0] LO = -HI - VW'(1);

  // Stage 1: round the quotient, half away from zero.
  logic          up;
  logic          v1_r;
  fpa_pkg::fpa_side_t s1_r;
  logic [NW:0]   qmag1_r;

  assign up = ({bk_rem, 1'b0} >= {1'b0, bk_den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= bk_vld;
    end
    s1_r    <= bk_side;
    qmag1_r <= {1'b0, bk_quo} + (NW+1)'(up);
  end

  // Stage 2: sign, saturation and flags.
  logic signed [VW-1:0] v_sel, qs;
  logic signed [OW-1:0] res_nxt;
  logic                 ov_nxt;

  always_comb begin
    qs    = $signed(VW'(qmag1_r));
    v_sel = s1_r.val;
    if (s1_r.op == fpa_pkg::OP_DIV) begin
      v_sel = s1_r.dz ? '0 : (s1_r.neg ? -qs : qs);
    end
    ov_nxt  = 1'b0;
    res_nxt = v_sel[OW-1:0];
    if (v_sel > HI) begin
      ov_nxt  = 1'b1;
      res_nxt = HI[OW-1:0];
    end else if (v_sel < LO) begin
      ov_nxt  = 1'b1;
      res_nxt = LO[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1_r;
    end
    out_result_value   <= res_nxt;
    out_compare_true   <= s1_r.cmp;
    out_overflow       <= ov_nxt;
    out_divide_by_zero <= s1_r.dz;
  end

endmodule

FILE: hw/rtl/fixed_point_alu_q24_8_top.sv
`timescale 1ns / 1ps
// Signed Q24.8 fixed-point arithmetic unit.
// Input channel: a transaction is taken at each rising edge with start high
// and busy low. busy is always low, so a new transaction can enter every
// cycle and the unit sustains one transaction per clock.
// in_opcode selects add, sub, mul, div, six comparisons, min, max, inc,
// dec, toint and fromint on the raw operands in_operand_a and in_operand_b.
// Result channel: out_valid is high for one cycle with the result fields;
// the receiver cannot stall, results leave in input order.
// The pipeline has 4 front-end stages (input register, multiplier, product
// rounding, product sign), one stage per two quotient bits of the 40-bit
// restoring divider (20 stages), and 2 back-end stages (quotient rounding,
// saturation); every opcode passes through all of them.
// Multiply and divide round half away from zero; results saturate with
// overflow set; divide by zero returns zero with divide_by_zero set.
// Synchronous reset clears all valid bits; no result appears until a new
// transaction has passed through the pipeline.
module fixed_point_alu_q24_8_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [3:0]                        in_opcode,
  input  logic signed [fpa_pkg::OPND_W-1:0] in_operand_a,
  input  logic signed [fpa_pkg::OPND_W-1:0] in_operand_b,
  output logic                              out_valid,
  output logic signed [fpa_pkg::OPND_W-1:0] out_result_value,
  output logic                              out_compare_true,
  output logic                              out_overflow,
  output logic                              out_divide_by_zero
);

  logic                         fr_vld, dv_vld;
  fpa_pkg::fpa_side_t           fr_side, dv_side;
  logic [fpa_pkg::NUMP_W-1:0]   fr_num, dv_quo;
  logic [fpa_pkg::OPND_W-1:0]   fr_den, dv_rem, dv_den;

  // The pipeline never stalls.
  assign busy = 1'b0;

  fpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_vld       (start & ~busy),
    .in_opcode    (in_opcode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .fr_vld       (fr_vld),
    .fr_side      (fr_side),
    .fr_num       (fr_num),
    .fr_den       (fr_den)
  );

  fpa_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .dv_in_vld   (fr_vld),
    .dv_in_side  (fr_side),
    .dv_in_num   (fr_num),
    .dv_in_den   (fr_den),
    .dv_out_vld  (dv_vld),
    .dv_out_side (dv_side),
    .dv_out_quo  (dv_quo),
    .dv_out_rem  (dv_rem),
    .dv_out_den  (dv_den)
  );

  fpa_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .bk_vld             (dv_vld),
    .bk_side            (dv_side),
    .bk_quo             (dv_quo),
    .bk_rem             (dv_rem),
    .bk_den             (dv_den),
    .out_valid          (out_valid),
    .out_result_value   (out_result_value),
    .out_compare_true   (out_compare_true),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule
